FILE: src/sus_pkg.sv
`default_nettype none

package sus_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned BP_W = 14;
    localparam int unsigned CRED_W = 7;
    localparam int unsigned ACT_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [ACT_W-1:0] ACT_LINK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_NET = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STALE_AFTER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNAVAIL_AFTER = 1'd1;

    localparam logic [WORD_W-1:0] STALE_AFTER_RST = 32'd30000;
    localparam logic [WORD_W-1:0] UNAVAIL_AFTER_RST = 32'd600000;

    localparam logic [BP_W-1:0] MAX_REMAINING_BP = 14'd10000;
    localparam logic [CRED_W-1:0] MAX_CREDITS = 7'd99;

    // floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
    localparam int unsigned MS_PER_S = 1000;
    localparam int unsigned DIV_MULT_W = 29;
    localparam int unsigned DIV_SHIFT = 38;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = 29'd274877907;
    localparam int unsigned PROD_W = WORD_W + DIV_MULT_W;
    localparam int unsigned ELAPSED_W = PROD_W - DIV_SHIFT;

    typedef struct packed {
        logic [WORD_W-1:0] last_sequence;
        logic [BP_W-1:0]   remaining;
        logic [WORD_W-1:0] quota_reset;
        logic [WORD_W-1:0] capture_epoch;
        logic [CRED_W-1:0] credits;
        logic [WORD_W-1:0] received_at;
        logic              has_data;
        logic [WORD_W-1:0] revision;
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] seq_number;
        logic [BP_W-1:0]   remaining_bp;
        logic [WORD_W-1:0] reset_time_s;
        logic [WORD_W-1:0] capture_time_s;
        logic [CRED_W-1:0] credit_count;
        logic [WORD_W-1:0] time_ms;
    } t_report;

endpackage

`default_nettype wire

FILE: src/sus_req_if.sv
`default_nettype none

interface sus_req_if;
    import sus_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] seq_number;
    logic [BP_W-1:0]   remaining_bp;
    logic [WORD_W-1:0] reset_time_s;
    logic [WORD_W-1:0] capture_time_s;
    logic [CRED_W-1:0] credit_count;
    logic [WORD_W-1:0] time_ms;

    modport source (
        output valid, action, seq_number, remaining_bp, reset_time_s,
               capture_time_s, credit_count, time_ms,
        input  ready
    );

    modport sink (
        input  valid, action, seq_number, remaining_bp, reset_time_s,
               capture_time_s, credit_count, time_ms,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/sus_rsp_if.sv
`default_nettype none

interface sus_rsp_if;
    import sus_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic              online;
    logic              usage_available;
    logic              usage_stale;
    logic              reset_available;
    logic [WORD_W-1:0] reset_seconds;
    logic [BP_W-1:0]   remaining_out;
    logic [CRED_W-1:0] credits_out;
    logic [WORD_W-1:0] revision_out;
    logic [WORD_W-1:0] last_seq_out;

    modport source (
        output valid, accepted, online, usage_available, usage_stale,
               reset_available, reset_seconds, remaining_out, credits_out,
               revision_out, last_seq_out,
        input  ready
    );

    modport sink (
        input  valid, accepted, online, usage_available, usage_stale,
               reset_available, reset_seconds, remaining_out, credits_out,
               revision_out, last_seq_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/sus_report.sv
`default_nettype none

module sus_report (
    input  wire sus_pkg::t_report i_rep,
    input  wire sus_pkg::t_state  i_state,
    output logic                  o_accepted,
    output sus_pkg::t_state       o_state
);
    import sus_pkg::*;

    logic              is_link;
    logic              is_net;
    logic              fields_ok;
    logic [WORD_W-1:0] seq_diff;
    logic              newer;
    logic              ok;
    logic              store;

    assign is_link = (i_rep.action == ACT_LINK);
    assign is_net = (i_rep.action == ACT_NET);

    assign fields_ok = (i_rep.remaining_bp <= MAX_REMAINING_BP)
                    && (i_rep.capture_time_s != '0)
                    && (i_rep.credit_count <= MAX_CREDITS)
                    && !(is_link && (i_rep.seq_number == '0));

    // serial compare: ahead by 1 .. 2^31-1, or nothing seen yet
    assign seq_diff = i_rep.seq_number - i_state.last_sequence;
    assign newer = (i_state.last_sequence == '0)
                || ((seq_diff != '0) && !seq_diff[WORD_W-1]);

    assign ok = (is_link || is_net) && fields_ok && (is_net || newer);
    assign store = ok && !(i_rep.capture_time_s < i_state.capture_epoch);
    assign o_accepted = ok;

    always_comb begin
        o_state = i_state;
        if (ok && is_link) begin
            o_state.last_sequence = i_rep.seq_number;
        end
        if (store) begin
            o_state.remaining = i_rep.remaining_bp;
            o_state.quota_reset = i_rep.reset_time_s;
            o_state.capture_epoch = i_rep.capture_time_s;
            o_state.credits = i_rep.credit_count;
            o_state.received_at = i_rep.time_ms;
            o_state.has_data = 1'b1;
            o_state.revision = i_state.revision + 1'b1;
        end
    end
endmodule

`default_nettype wire

FILE: src/sequenced_usage_status_register_core.sv
`default_nettype none

// channel   dir  modport  payload
// i_req     in   sink     action, seq_number, remaining_bp, reset/capture epochs,
//                         credit_count, time_ms
// o_rsp     out  source   flags, reset_seconds, stored fields, revision, last seq
// i_cfg_*   in   -        write enable, register index, 32-bit data
//
// five register stages: input, state update, age and limits, divide by 1000
// by reciprocal multiply, result; one beat per cycle while the output is not stalled.
// the stored report updates when a beat leaves the input stage, so the next
// beat sees it at once. each stage holds while the one after it is full and
// stalled; synchronous reset empties the pipe and restores state and limits.

module sequenced_usage_status_register_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [sus_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [sus_pkg::WORD_W-1:0]     i_cfg_data,
    sus_req_if.sink                       i_req,
    sus_rsp_if.source                     o_rsp
);
    import sus_pkg::*;

    logic [WORD_W-1:0] r_stale_after;
    logic [WORD_W-1:0] r_unavail_after;

    t_state  r_state;
    t_state  n_state;
    t_report n_rep;
    logic    n_accepted;

    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !r5_valid || o_rsp.ready;
    assign rdy4 = !r4_valid || rdy5;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;
    assign i_req.ready = rdy1;

    // stage 1: input
    t_report r1_rep;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_rep <= '{i_req.action, i_req.seq_number, i_req.remaining_bp,
                        i_req.reset_time_s, i_req.capture_time_s,
                        i_req.credit_count, i_req.time_ms};
        end
    end

    assign n_rep = r1_rep;

    sus_report u_report (
        .i_rep      (n_rep),
        .i_state    (r_state),
        .o_accepted (n_accepted),
        .o_state    (n_state)
    );

    // stage 2: state after this beat
    logic              r2_acc;
    logic [WORD_W-1:0] r2_now;
    t_state            r2_st;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_acc <= n_accepted;
            r2_now <= r1_rep.time_ms;
            r2_st  <= n_state;
        end
    end

    // stage 3: age and limits
    logic [WORD_W-1:0] n3_age;
    logic              r3_acc, r3_online, r3_avail, r3_over, r3_rgt;
    logic [WORD_W-1:0] r3_age, r3_initial;
    logic [BP_W-1:0]   r3_rem;
    logic [CRED_W-1:0] r3_cred;
    logic [WORD_W-1:0] r3_rev, r3_seq;

    assign n3_age = r2_st.has_data ? (r2_now - r2_st.received_at) : '1;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_acc     <= r2_acc;
            r3_age     <= n3_age;
            r3_online  <= r2_st.has_data && (n3_age <= r_stale_after);
            r3_avail   <= r2_st.has_data && (n3_age <= r_unavail_after);
            r3_over    <= (n3_age > r_stale_after);
            r3_rgt     <= (r2_st.quota_reset > r2_st.capture_epoch);
            r3_initial <= r2_st.quota_reset - r2_st.capture_epoch;
            r3_rem     <= r2_st.remaining;
            r3_cred    <= r2_st.credits;
            r3_rev     <= r2_st.revision;
            r3_seq     <= r2_st.last_sequence;
        end
    end

    // stage 4: whole seconds of age
    logic [PROD_W-1:0]    n4_prod;
    logic [ELAPSED_W-1:0] r4_elapsed;
    logic                 r4_acc, r4_online, r4_avail, r4_over, r4_rgt;
    logic [WORD_W-1:0]    r4_initial;
    logic [BP_W-1:0]      r4_rem;
    logic [CRED_W-1:0]    r4_cred;
    logic [WORD_W-1:0]    r4_rev, r4_seq;

    assign n4_prod = PROD_W'(r3_age) * PROD_W'(DIV_MULT);

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_elapsed <= n4_prod[DIV_SHIFT +: ELAPSED_W];
            r4_acc     <= r3_acc;
            r4_online  <= r3_online;
            r4_avail   <= r3_avail;
            r4_over    <= r3_over;
            r4_rgt     <= r3_rgt;
            r4_initial <= r3_initial;
            r4_rem     <= r3_rem;
            r4_cred    <= r3_cred;
            r4_rev     <= r3_rev;
            r4_seq     <= r3_seq;
        end
    end

    // stage 5: countdown and result
    logic              n5_rok;
    logic [WORD_W-1:0] n5_elapsed;
    logic [WORD_W-1:0] n5_secs;
    logic              n5_stale;

    logic              r5_acc, r5_online, r5_avail, r5_stale, r5_rok;
    logic [WORD_W-1:0] r5_secs;
    logic [BP_W-1:0]   r5_rem;
    logic [CRED_W-1:0] r5_cred;
    logic [WORD_W-1:0] r5_rev, r5_seq;

    assign n5_rok = r4_avail && r4_rgt;
    assign n5_elapsed = WORD_W'(r4_elapsed);
    assign n5_secs = (n5_rok && (n5_elapsed < r4_initial))
                   ? (r4_initial - n5_elapsed) : '0;
    assign n5_stale = (r4_avail && r4_over)
                   || (n5_rok && (n5_secs == '0) && r4_over);

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r5_acc    <= r4_acc;
            r5_online <= r4_online;
            r5_avail  <= r4_avail;
            r5_stale  <= n5_stale;
            r5_rok    <= n5_rok;
            r5_secs   <= n5_secs;
            r5_rem    <= r4_rem;
            r5_cred   <= r4_cred;
            r5_rev    <= r4_rev;
            r5_seq    <= r4_seq;
        end
    end

    assign o_rsp.valid           = r5_valid;
    assign o_rsp.accepted        = r5_acc;
    assign o_rsp.online          = r5_online;
    assign o_rsp.usage_available = r5_avail;
    assign o_rsp.usage_stale     = r5_stale;
    assign o_rsp.reset_available = r5_rok;
    assign o_rsp.reset_seconds   = r5_secs;
    assign o_rsp.remaining_out   = r5_rem;
    assign o_rsp.credits_out     = r5_cred;
    assign o_rsp.revision_out    = r5_rev;
    assign o_rsp.last_seq_out    = r5_seq;

    // control, state and limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid        <= 1'b0;
            r2_valid        <= 1'b0;
            r3_valid        <= 1'b0;
            r4_valid        <= 1'b0;
            r5_valid        <= 1'b0;
            r_state         <= '0;
            r_stale_after   <= STALE_AFTER_RST;
            r_unavail_after <= UNAVAIL_AFTER_RST;
        end else begin
            if (rdy1) r1_valid <= i_req.valid;
            if (rdy2) r2_valid <= r1_valid;
            if (rdy3) r3_valid <= r2_valid;
            if (rdy4) r4_valid <= r3_valid;
            if (rdy5) r5_valid <= r4_valid;
            if (r1_valid && rdy2) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STALE_AFTER:   r_stale_after <= i_cfg_data;
                    CFG_UNAVAIL_AFTER: r_unavail_after <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

`default_nettype wire

FILE: verif/sequenced_usage_status_register_core_tb.sv
`default_nettype none

module sequenced_usage_status_register_core_tb;
    import sus_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned CHUNK_ITEMS = 250;

    typedef struct packed {
        bit              accepted;
        bit              online;
        bit              usage_available;
        bit              usage_stale;
        bit              reset_available;
        bit [WORD_W-1:0] reset_seconds;
        bit [BP_W-1:0]   remaining_out;
        bit [CRED_W-1:0] credits_out;
        bit [WORD_W-1:0] revision_out;
        bit [WORD_W-1:0] last_seq_out;
    } t_snapshot;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0] cfg_data;

    sus_req_if req_if ();
    sus_rsp_if rsp_if ();

    sequenced_usage_status_register_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source)
    );

    // predicted register state and limits
    bit [WORD_W-1:0] stale_lim;
    bit [WORD_W-1:0] unavail_lim;
    bit [WORD_W-1:0] link_seq;
    bit [BP_W-1:0]   keep_remaining;
    bit [WORD_W-1:0] keep_quota_reset;
    bit [WORD_W-1:0] keep_capture_epoch;
    bit [CRED_W-1:0] keep_credits;
    bit [WORD_W-1:0] keep_rx_ms;
    bit              keep_valid;
    bit [WORD_W-1:0] keep_revision;

    // stimulus generation state
    bit [WORD_W-1:0] gen_seq;
    bit [WORD_W-1:0] gen_cap;
    bit [WORD_W-1:0] gen_ms;
    bit [WORD_W-1:0] last_rpt_ms;

    t_report   outbound_reports[$];
    t_snapshot due_snapshots[$];
    t_report   offer;
    t_snapshot want;

    int unsigned n_queued;
    int unsigned n_seen;
    int unsigned mismatches;
    int unsigned src_idle;
    int unsigned snk_idle;
    int unsigned quiet;
    int unsigned hold_left;
    logic        hold_start;

    function automatic bit apply_report(t_report r);
        bit net;
        bit [WORD_W-1:0] d;
        net = (r.action == ACT_NET);
        if ((!net && r.seq_number == 0) || r.remaining_bp > MAX_REMAINING_BP ||
            r.capture_time_s == 0 || r.credit_count > MAX_CREDITS)
            return 1'b0;
        d = r.seq_number - link_seq;
        if (!net && !(link_seq == 0 || (d != 0 && d < 32'h8000_0000)))
            return 1'b0;
        if (!net)
            link_seq = r.seq_number;
        if (r.capture_time_s < keep_capture_epoch)
            return 1'b1;
        keep_remaining = r.remaining_bp;
        keep_quota_reset = r.reset_time_s;
        keep_capture_epoch = r.capture_time_s;
        keep_credits = r.credit_count;
        keep_rx_ms = r.time_ms;
        keep_valid = 1'b1;
        keep_revision = keep_revision + 1;
        return 1'b1;
    endfunction

    function automatic t_snapshot next_snapshot(t_report r);
        t_snapshot s;
        bit [WORD_W-1:0] age;
        bit [WORD_W-1:0] span;
        bit [WORD_W-1:0] elapsed;
        s = '0;
        if (r.action == ACT_LINK || r.action == ACT_NET)
            s.accepted = apply_report(r);
        age = keep_valid ? r.time_ms - keep_rx_ms : 32'hFFFF_FFFF;
        s.online = keep_valid && age <= stale_lim;
        s.usage_available = keep_valid && age <= unavail_lim;
        s.usage_stale = s.usage_available && age > stale_lim;
        if (s.usage_available && keep_quota_reset > keep_capture_epoch) begin
            span = keep_quota_reset - keep_capture_epoch;
            elapsed = age / MS_PER_S;
            s.reset_available = 1'b1;
            s.reset_seconds = elapsed < span ? span - elapsed : 0;
            if (s.reset_seconds == 0 && age > stale_lim)
                s.usage_stale = 1'b1;
        end
        s.remaining_out = keep_remaining;
        s.credits_out = keep_credits;
        s.revision_out = keep_revision;
        s.last_seq_out = link_seq;
        return s;
    endfunction

    function automatic t_report mk(logic [ACT_W-1:0] act, logic [WORD_W-1:0] seq,
                                   logic [BP_W-1:0] rem, logic [WORD_W-1:0] rst,
                                   logic [WORD_W-1:0] cap, logic [CRED_W-1:0] cred,
                                   logic [WORD_W-1:0] now);
        t_report r;
        r.action = act;
        r.seq_number = seq;
        r.remaining_bp = rem;
        r.reset_time_s = rst;
        r.capture_time_s = cap;
        r.credit_count = cred;
        r.time_ms = now;
        return r;
    endfunction

    function automatic t_report random_report();
        t_report r;
        int unsigned pick;
        pick = $urandom_range(99);
        r.action = pick < 45 ? ACT_LINK : pick < 75 ? ACT_NET : pick < 95 ? ACT_QUERY
                 : ACT_UNUSED;

        pick = $urandom_range(99);
        if (pick < 80) begin
            gen_seq = gen_seq + $urandom_range(1, 3);
            r.seq_number = gen_seq;
        end else if (pick < 88) begin
            r.seq_number = gen_seq;
        end else if (pick < 93) begin
            r.seq_number = gen_seq - $urandom_range(1, 4);
        end else if (pick < 97) begin
            gen_seq = $urandom;
            r.seq_number = gen_seq;
        end else begin
            r.seq_number = 0;
        end

        pick = $urandom_range(99);
        if (pick < 80)
            gen_cap = gen_cap + $urandom_range(0, 5);
        else if (pick < 90)
            gen_cap = gen_cap - $urandom_range(1, 5);
        else if (pick < 94)
            gen_cap = $urandom;
        r.capture_time_s = (pick >= 94 && pick < 97) ? 32'd0 : gen_cap;

        pick = $urandom_range(99);
        if (pick < 70)
            r.reset_time_s = gen_cap + $urandom_range(0, 900);
        else if (pick < 80)
            r.reset_time_s = gen_cap - $urandom_range(1, 50);
        else if (pick < 90)
            r.reset_time_s = gen_cap;
        else
            r.reset_time_s = $urandom;

        pick = $urandom_range(99);
        r.remaining_bp = pick < 85 ? BP_W'($urandom_range(0, 10000))
                       : pick < 90 ? MAX_REMAINING_BP : BP_W'($urandom_range(10001, 16383));
        pick = $urandom_range(99);
        r.credit_count = pick < 85 ? CRED_W'($urandom_range(0, 99))
                       : pick < 90 ? MAX_CREDITS : CRED_W'($urandom_range(100, 127));

        pick = $urandom_range(99);
        if (pick < 60)
            gen_ms = gen_ms + $urandom_range(0, 3000);
        else if (pick < 80)
            gen_ms = gen_ms + $urandom_range(0, 40000);
        else if (pick < 88)
            gen_ms = gen_ms + $urandom_range(0, 800000);
        else if (pick < 92)
            gen_ms = $urandom;
        else if (pick < 96)
            gen_ms = last_rpt_ms + stale_lim + $urandom_range(0, 1);
        else
            gen_ms = last_rpt_ms + unavail_lim + $urandom_range(0, 1);
        r.time_ms = gen_ms;
        if (r.action == ACT_LINK || r.action == ACT_NET)
            last_rpt_ms = gen_ms;
        return r;
    endfunction

    task automatic queue_report(t_report r);
        outbound_reports.push_back(r);
        n_queued++;
    endtask

    task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] exp_val);
        mismatches++;
        $display("mismatch on %s: got %0h, predicted %0h (beat %0d)",
                 field, got, exp_val, n_seen);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_STALE_AFTER)
            stale_lim = val;
        else
            unavail_lim = val;
    endtask

    task automatic drain();
        while (n_seen < n_queued)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                due_snapshots.push_back(next_snapshot(offer));
            if (!req_if.valid || req_if.ready) begin
                if (outbound_reports.size() != 0 && $urandom_range(99) >= src_idle) begin
                    offer = outbound_reports.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.action <= offer.action;
                    req_if.seq_number <= offer.seq_number;
                    req_if.remaining_bp <= offer.remaining_bp;
                    req_if.reset_time_s <= offer.reset_time_s;
                    req_if.capture_time_s <= offer.capture_time_s;
                    req_if.credit_count <= offer.credit_count;
                    req_if.time_ms <= offer.time_ms;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_seen++;
                if (due_snapshots.size() == 0) begin
                    report_mismatch("beat with nothing due", 0, 0);
                end else begin
                    want = due_snapshots.pop_front();
                    if (rsp_if.accepted !== want.accepted)
                        report_mismatch("accepted", rsp_if.accepted, want.accepted);
                    if (rsp_if.online !== want.online)
                        report_mismatch("online", rsp_if.online, want.online);
                    if (rsp_if.usage_available !== want.usage_available)
                        report_mismatch("usage_available", rsp_if.usage_available,
                                        want.usage_available);
                    if (rsp_if.usage_stale !== want.usage_stale)
                        report_mismatch("usage_stale", rsp_if.usage_stale, want.usage_stale);
                    if (rsp_if.reset_available !== want.reset_available)
                        report_mismatch("reset_available", rsp_if.reset_available,
                                        want.reset_available);
                    if (rsp_if.reset_seconds !== want.reset_seconds)
                        report_mismatch("reset_seconds", rsp_if.reset_seconds,
                                        want.reset_seconds);
                    if (rsp_if.remaining_out !== want.remaining_out)
                        report_mismatch("remaining_out", rsp_if.remaining_out,
                                        want.remaining_out);
                    if (rsp_if.credits_out !== want.credits_out)
                        report_mismatch("credits_out", rsp_if.credits_out, want.credits_out);
                    if (rsp_if.revision_out !== want.revision_out)
                        report_mismatch("revision_out", rsp_if.revision_out, want.revision_out);
                    if (rsp_if.last_seq_out !== want.last_seq_out)
                        report_mismatch("last_seq_out", rsp_if.last_seq_out, want.last_seq_out);
                end
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int unsigned c;
        int unsigned k;
        bit [WORD_W-1:0] s_lim;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.action = ACT_QUERY;
        req_if.seq_number = '0;
        req_if.remaining_bp = '0;
        req_if.reset_time_s = '0;
        req_if.capture_time_s = '0;
        req_if.credit_count = '0;
        req_if.time_ms = '0;
        rsp_if.ready = 1'b0;
        hold_start = 1'b0;
        hold_left = 0;
        quiet = 0;
        n_queued = 0;
        n_seen = 0;
        mismatches = 0;
        src_idle = 0;
        snk_idle = 0;
        stale_lim = STALE_AFTER_RST;
        unavail_lim = UNAVAIL_AFTER_RST;
        link_seq = 0;
        keep_remaining = 0;
        keep_quota_reset = 0;
        keep_capture_epoch = 0;
        keep_credits = 0;
        keep_rx_ms = 0;
        keep_valid = 1'b0;
        keep_revision = 0;
        gen_seq = 32'd100;
        gen_cap = 32'd1_000_000;
        gen_ms = 32'd10_000_000;
        last_rpt_ms = gen_ms;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty state, range rejects, serial order, older capture, wrap
        queue_report(mk(ACT_QUERY, 0, 0, 0, 0, 0, 0));
        queue_report(mk(ACT_LINK, 0, 5000, 2000, 1000, 10, 1000));
        queue_report(mk(ACT_LINK, 5, MAX_REMAINING_BP, 2000, 1000, MAX_CREDITS, 1000));
        queue_report(mk(ACT_LINK, 5, 100, 2000, 1000, 1, 1100));
        queue_report(mk(ACT_LINK, 32'h8000_0005, 100, 2000, 1000, 1, 1200));
        queue_report(mk(ACT_LINK, 4, 100, 2000, 1000, 1, 1300));
        queue_report(mk(ACT_NET, 7, 10001, 2000, 1000, 1, 1400));
        queue_report(mk(ACT_NET, 7, 100, 2000, 0, 1, 1500));
        queue_report(mk(ACT_NET, 7, 100, 2000, 1000, 100, 1600));
        queue_report(mk(ACT_NET, 7, 14'h3FFF, 2000, 1000, 7'h7F, 1700));
        queue_report(mk(ACT_LINK, 6, 200, 3000, 999, 2, 1800));
        queue_report(mk(ACT_NET, 0, 0, 1000, 1000, 0, 5000));
        queue_report(mk(ACT_UNUSED, 32'hFFFF_FFFF, 14'h3FFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 7'h7F, 35000));
        queue_report(mk(ACT_QUERY, 0, 0, 0, 0, 0, 35001));
        queue_report(mk(ACT_QUERY, 0, 0, 0, 0, 0, 605000));
        queue_report(mk(ACT_QUERY, 0, 0, 0, 0, 0, 605001));
        queue_report(mk(ACT_NET, 0, 9999, 32'hFFFF_FFFF, 32'hFFFF_0000, 50, 32'hFFFF_FFF0));
        queue_report(mk(ACT_QUERY, 0, 0, 0, 0, 0, 32'h0000_0010));
        queue_report(mk(ACT_NET, 0, 1, 32'hFFFF_000A, 32'hFFFF_0000, 1, 100000));
        queue_report(mk(ACT_QUERY, 0, 0, 0, 0, 0, 120000));
        queue_report(mk(ACT_LINK, 32'h8000_0005, 2, 32'hFFFF_0010, 32'hFFFF_0001, 3, 121000));
        queue_report(mk(ACT_LINK, 32'hFFFF_FFFF, 3, 32'hFFFF_0010, 32'hFFFF_0002, 4, 122000));
        queue_report(mk(ACT_LINK, 1, 4, 32'hFFFF_0010, 32'hFFFF_0003, 5, 123000));
        drain();

        for (c = 0; c < 5; c++) begin
            case (c)
                0: begin
                    write_limit(CFG_STALE_AFTER, 32'd0);
                    write_limit(CFG_UNAVAIL_AFTER, 32'hFFFF_FFFF);
                end
                1: begin
                    write_limit(CFG_STALE_AFTER, 32'hFFFF_FFFF);
                    write_limit(CFG_UNAVAIL_AFTER, 32'd0);
                end
                2: begin
                    write_limit(CFG_STALE_AFTER, 32'd5000);
                    write_limit(CFG_UNAVAIL_AFTER, 32'd60000);
                end
                3: begin
                    s_lim = $urandom_range(1000, 60000);
                    write_limit(CFG_STALE_AFTER, s_lim);
                    write_limit(CFG_UNAVAIL_AFTER, s_lim + $urandom_range(0, 700000));
                end
                default: begin
                    write_limit(CFG_STALE_AFTER, STALE_AFTER_RST);
                    write_limit(CFG_UNAVAIL_AFTER, UNAVAIL_AFTER_RST);
                end
            endcase
            src_idle <= (c < 2) ? 15 : (c < 4) ? 77 : 0;
            snk_idle <= (c < 2) ? 77 : (c < 4) ? 15 : 0;
            for (k = 0; k < CHUNK_ITEMS; k++)
                queue_report(random_report());
            if (c == 4) begin
                repeat (20) @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            drain();
        end

        if (due_snapshots.size() != 0)
            report_mismatch("snapshots never delivered", due_snapshots.size(), 0);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
